// ===== rtl/core/fpr_pkg.sv =====
// shared types and constants of the framed packet receiver
`default_nettype none

package fpr_pkg;

   localparam int TimerWidth = 17;

   localparam logic [1:0] OP_ARM  = 2'd0;
   localparam logic [1:0] OP_BYTE = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_START_TMO  = 3'd1;
   localparam logic [2:0] ST_HEADER_TMO = 3'd2;
   localparam logic [2:0] ST_OVERFLOW   = 3'd3;
   localparam logic [2:0] ST_DATA_TMO   = 3'd4;
   localparam logic [2:0] ST_END_TMO    = 3'd5;
   localparam logic [2:0] ST_WRONG_END  = 3'd6;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [1:0] REG_START_MARKER  = 2'd0;
   localparam logic [1:0] REG_END_MARKER    = 2'd1;
   localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd2;
   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

   localparam logic [7:0]  RST_START_MARKER  = 8'd170;
   localparam logic [7:0]  RST_END_MARKER    = 8'd85;
   localparam logic [7:0]  RST_MAX_PAYLOAD   = 8'd64;
   localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd100;

   typedef struct packed {
      logic [7:0]  start_marker;
      logic [7:0]  end_marker;
      logic [7:0]  max_payload;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] payload_byte;
      logic [2:0] status;
      logic [7:0] packet_address;
      logic [7:0] packet_length;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/framed_packet_receiver.sv =====
// top level of the framed packet receiver: input register, receive step, result register
//
//  channel | direction | handshake          | fields
//  req     | in        | req_valid/req_stall | operation, rx_byte
//  rsp     | out       | rsp_valid/rsp_stall | item_kind, payload_byte, status,
//          |           |                     | packet_address, packet_length, last
//  csr     | in/out    | apb-style write     | start_marker, end_marker, max_payload,
//          |           |                     | timeout_ticks
//
// one item per cycle while rsp_stall does not hold a full result register
// the input register and the result register each hold one item, so an item is
// taken while a finished result waits; req_stall rises only when both are full
// reset is synchronous and clears both valid bits, the phase and the timer
`default_nettype none

module framed_packet_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_item_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_packet_address,
   output logic [7:0]       rsp_packet_length,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import fpr_pkg::*;

   cfg_type    cfg;
   logic       in_vld_ff;
   logic [1:0] in_op_ff;
   logic [7:0] in_byte_ff;
   logic       out_vld_ff;
   result_type out_ff;
   logic       can_move;
   logic       advance;
   logic       step_emit;
   result_type step_result;

   fpr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign can_move  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && can_move;
   assign req_stall = in_vld_ff && !can_move;

   fpr_step u_step (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .operation (in_op_ff),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg),
      .emit      (step_emit),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_op_ff   <= req_operation;
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (can_move) begin
         out_vld_ff <= advance && step_emit;
      end
      if (advance && step_emit) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_item_kind      = out_ff.item_kind;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_status         = out_ff.status;
   assign rsp_packet_address = out_ff.packet_address;
   assign rsp_packet_length  = out_ff.packet_length;
   assign rsp_last           = out_ff.item_kind;

endmodule

`default_nettype wire

// ===== rtl/core/fpr_csr.sv =====
// configuration registers of the framed packet receiver behind an apb-style port
`default_nettype none

module fpr_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_psel,
   input  wire logic           csr_penable,
   input  wire logic           csr_pwrite,
   input  wire logic [3:0]     csr_paddr,
   input  wire logic [31:0]    csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output fpr_pkg::cfg_type    cfg
);
   import fpr_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker  <= RST_START_MARKER;
         cfg_ff.end_marker    <= RST_END_MARKER;
         cfg_ff.max_payload   <= RST_MAX_PAYLOAD;
         cfg_ff.timeout_ticks <= RST_TIMEOUT_TICKS;
      end else if (wr_en) begin
         case (reg_index)
            REG_START_MARKER:  cfg_ff.start_marker  <= csr_pwdata[7:0];
            REG_END_MARKER:    cfg_ff.end_marker    <= csr_pwdata[7:0];
            REG_MAX_PAYLOAD:   cfg_ff.max_payload   <= csr_pwdata[7:0];
            REG_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_START_MARKER:  csr_prdata = {24'd0, cfg_ff.start_marker};
         REG_END_MARKER:    csr_prdata = {24'd0, cfg_ff.end_marker};
         REG_MAX_PAYLOAD:   csr_prdata = {24'd0, cfg_ff.max_payload};
         REG_TIMEOUT_TICKS: csr_prdata = {16'd0, cfg_ff.timeout_ticks};
         default:           csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/fpr_step.sv =====
// receive fsm: phase, timeout timer, header fields; one item per cycle on advance
`default_nettype none

module fpr_step (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire logic [1:0]     operation,
   input  wire logic [7:0]     rx_byte,
   input  wire fpr_pkg::cfg_type cfg,
   output logic                emit,
   output fpr_pkg::result_type result
);
   import fpr_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_HUNT = 3'd1,
      PH_LEN  = 3'd2,
      PH_ADDR = 3'd3,
      PH_DATA = 3'd4,
      PH_END  = 3'd5
   } phase_type;

   localparam logic [TimerWidth-1:0] TimerMax = '1;

   phase_type             phase_ff, phase_in;
   logic [TimerWidth-1:0] timer_ff, timer_in, timer_inc;
   logic [7:0]            left_ff, left_in, left_dec;
   logic [7:0]            length_ff, length_in;
   logic [7:0]            address_ff, address_in;
   logic                  timed_out;
   logic [2:0]            tmo_status;

   assign timer_inc = (timer_ff == TimerMax) ? timer_ff : timer_ff + 1'b1;
   assign timed_out = timer_inc > {1'b0, cfg.timeout_ticks};
   assign left_dec  = left_ff - 8'd1;

   always_comb begin
      case (phase_ff)
         PH_HUNT: tmo_status = ST_START_TMO;
         PH_DATA: tmo_status = ST_DATA_TMO;
         PH_END:  tmo_status = ST_END_TMO;
         default: tmo_status = ST_HEADER_TMO;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      timer_in   = timer_ff;
      left_in    = left_ff;
      length_in  = length_ff;
      address_in = address_ff;
      emit       = 1'b0;
      result     = '0;
      if (operation == OP_ARM) begin
         phase_in   = PH_HUNT;
         timer_in   = '0;
         left_in    = '0;
         length_in  = '0;
         address_in = '0;
      end else if (phase_ff != PH_IDLE && operation == OP_TICK) begin
         timer_in = timer_inc;
         if (timed_out) begin
            phase_in         = PH_IDLE;
            timer_in         = '0;
            emit             = 1'b1;
            result.item_kind = KIND_STATUS;
            result.status    = tmo_status;
         end
      end else if (phase_ff != PH_IDLE && operation == OP_BYTE) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == cfg.start_marker) phase_in = PH_LEN;
            end
            PH_LEN: begin
               length_in = rx_byte;
               phase_in  = PH_ADDR;
            end
            PH_ADDR: begin
               address_in = rx_byte;
               if (length_ff > cfg.max_payload) begin
                  phase_in         = PH_IDLE;
                  timer_in         = '0;
                  emit             = 1'b1;
                  result.item_kind = KIND_STATUS;
                  result.status    = ST_OVERFLOW;
               end else begin
                  left_in  = length_ff;
                  timer_in = '0;
                  phase_in = (length_ff == 8'd0) ? PH_END : PH_DATA;
               end
            end
            PH_DATA: begin
               left_in             = left_dec;
               timer_in            = '0;
               if (left_dec == 8'd0) phase_in = PH_END;
               emit                = 1'b1;
               result.item_kind    = KIND_PAYLOAD;
               result.payload_byte = rx_byte;
            end
            PH_END: begin
               phase_in         = PH_IDLE;
               timer_in         = '0;
               emit             = 1'b1;
               result.item_kind = KIND_STATUS;
               if (rx_byte != cfg.end_marker) begin
                  result.status = ST_WRONG_END;
               end else begin
                  result.status         = ST_OK;
                  result.packet_address = address_ff;
                  result.packet_length  = length_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         timer_ff   <= '0;
         left_ff    <= '0;
         length_ff  <= '0;
         address_ff <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         timer_ff   <= timer_in;
         left_ff    <= left_in;
         length_ff  <= length_in;
         address_ff <= address_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_framed_packet_receiver.sv =====
// self-checking testbench for the framed packet receiver: directed and random packets
module tb_framed_packet_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   import fpr_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int CycleLimit = 400_000;
   localparam int PhaseItems = 190;

   typedef enum logic [2:0] {
      RX_IDLE, RX_HUNT, RX_LENGTH, RX_ADDRESS, RX_DATA, RX_END_BYTE
   } rx_phase_t;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [2:0] status;
      logic [7:0] address;
      logic [7:0] length;
      logic       last;
   } deframed_t;

   class deframe_scoreboard;
      cfg_type cfg = '{start_marker: RST_START_MARKER, end_marker: RST_END_MARKER,
                       max_payload: RST_MAX_PAYLOAD, timeout_ticks: RST_TIMEOUT_TICKS};
      rx_phase_t phase = RX_IDLE;
      logic [TimerWidth-1:0] ticks_waited = '0;
      logic [7:0] bytes_left = '0;
      logic [7:0] held_length = '0;
      logic [7:0] held_address = '0;
      deframed_t due_items[$];
      int errors = 0;

      function void load_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_START_MARKER:  cfg.start_marker = value[7:0];
            REG_END_MARKER:    cfg.end_marker = value[7:0];
            REG_MAX_PAYLOAD:   cfg.max_payload = value[7:0];
            REG_TIMEOUT_TICKS: cfg.timeout_ticks = value[15:0];
            default: ;
         endcase
      endfunction

      function void close_receive(logic [2:0] code, logic [7:0] address, logic [7:0] length);
         phase = RX_IDLE;
         ticks_waited = '0;
         due_items.push_back(deframed_t'{kind: KIND_STATUS, data: 8'h00, status: code,
                                         address: address, length: length, last: 1'b1});
      endfunction

      function void note_item(logic [1:0] op, logic [7:0] value);
         if (op == OP_ARM) begin
            phase = RX_HUNT;
            ticks_waited = '0;
            bytes_left = '0;
            held_length = '0;
            held_address = '0;
            return;
         end
         if (phase == RX_IDLE || op == OP_SPARE) return;
         if (op == OP_TICK) begin
            if (ticks_waited != '1) ticks_waited++;
            if (ticks_waited > {1'b0, cfg.timeout_ticks}) begin
               case (phase)
                  RX_HUNT:     close_receive(ST_START_TMO, 8'h00, 8'h00);
                  RX_DATA:     close_receive(ST_DATA_TMO, 8'h00, 8'h00);
                  RX_END_BYTE: close_receive(ST_END_TMO, 8'h00, 8'h00);
                  default:     close_receive(ST_HEADER_TMO, 8'h00, 8'h00);
               endcase
            end
            return;
         end
         case (phase)
            RX_HUNT: if (value == cfg.start_marker) phase = RX_LENGTH;
            RX_LENGTH: begin
               held_length = value;
               phase = RX_ADDRESS;
            end
            RX_ADDRESS: begin
               held_address = value;
               if (held_length > cfg.max_payload) begin
                  close_receive(ST_OVERFLOW, 8'h00, 8'h00);
               end else begin
                  bytes_left = held_length;
                  ticks_waited = '0;
                  phase = (held_length == 8'd0) ? RX_END_BYTE : RX_DATA;
               end
            end
            RX_DATA: begin
               bytes_left--;
               ticks_waited = '0;
               if (bytes_left == 8'd0) phase = RX_END_BYTE;
               due_items.push_back(deframed_t'{kind: KIND_PAYLOAD, data: value, status: ST_OK,
                                               address: 8'h00, length: 8'h00, last: 1'b0});
            end
            default: begin
               if (value != cfg.end_marker) close_receive(ST_WRONG_END, 8'h00, 8'h00);
               else close_receive(ST_OK, held_address, held_length);
            end
         endcase
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         end
      endfunction

      function void check_result(deframed_t got);
         deframed_t want;
         if (due_items.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual kind %0d byte 0x%0h status %0d",
                     $time, got.kind, got.data, got.status);
            return;
         end
         want = due_items.pop_front();
         check_field("item_kind", want.kind, got.kind);
         check_field("payload_byte", want.data, got.data);
         check_field("status", want.status, got.status);
         check_field("packet_address", want.address, got.address);
         check_field("packet_length", want.length, got.length);
         check_field("last", want.last, got.last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_ARM;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_item_kind;
   logic [7:0]  rsp_payload_byte;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_packet_address;
   logic [7:0]  rsp_packet_length;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'h0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   deframe_scoreboard sb = new();
   int idle_pct = 30;
   int stall_pct = 30;
   int hold_cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int sent = 0;
   int cycle_count = 0;

   framed_packet_receiver u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item_kind(rsp_item_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_status(rsp_status),
      .rsp_packet_address(rsp_packet_address),
      .rsp_packet_length(rsp_packet_length),
      .rsp_last(rsp_last),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_item(req_operation, req_rx_byte);
         if (rsp_valid && !rsp_stall)
            sb.check_result(deframed_t'{kind: rsp_item_kind, data: rsp_payload_byte,
                                        status: rsp_status, address: rsp_packet_address,
                                        length: rsp_packet_length, last: rsp_last});
      end
   end

   // receiver side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (!hold_done && hold_cycles > 0) begin
         hold_done <= 1'b1;
         hold_left <= hold_cycles;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [7:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_rx_byte <= value;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.load_register(idx, value);
      @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.due_items.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic maybe_ticks();
      int cap;
      cap = (sb.cfg.timeout_ticks < 3) ? sb.cfg.timeout_ticks + 1 : 3;
      if ($urandom_range(0, 99) < 20)
         repeat ($urandom_range(0, cap)) send_item(OP_TICK, 8'($urandom));
   endtask

   task automatic send_packet();
      logic [7:0] length;
      logic [7:0] noise;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
         return;
      end
      send_item(OP_ARM, 8'($urandom));
      repeat ($urandom_range(0, 2)) begin
         noise = 8'($urandom);
         if (noise == sb.cfg.start_marker) noise = ~noise;
         send_item(OP_BYTE, noise);
      end
      maybe_ticks();
      send_item(OP_BYTE, sb.cfg.start_marker);
      roll = $urandom_range(0, 99);
      if (roll < 85)
         length = 8'($urandom_range(0, (sb.cfg.max_payload < 6) ? sb.cfg.max_payload : 6));
      else if (roll < 93)
         length = sb.cfg.max_payload;
      else
         length = (sb.cfg.max_payload == 8'hFF) ? 8'hFF : sb.cfg.max_payload + 8'd1;
      maybe_ticks();
      send_item(OP_BYTE, length);
      maybe_ticks();
      send_item(OP_BYTE, 8'($urandom));
      if (length > sb.cfg.max_payload) return;
      for (int i = 0; i < length; i++) begin
         // abandon the receive with a fresh arm
         if ($urandom_range(0, 99) < 2) begin
            send_item(OP_ARM, 8'($urandom));
            return;
         end
         maybe_ticks();
         send_item(OP_BYTE, 8'($urandom));
      end
      maybe_ticks();
      if ($urandom_range(0, 99) < 88) send_item(OP_BYTE, sb.cfg.end_marker);
      else send_item(OP_BYTE, sb.cfg.end_marker ^ 8'($urandom_range(1, 255)));
   endtask

   initial begin
      int target;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // good packet behind a noise byte, two payload bytes at the extremes
      send_item(OP_ARM, 8'h00);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, RST_START_MARKER);
      send_item(OP_BYTE, 8'h02);
      send_item(OP_BYTE, 8'h5A);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, RST_END_MARKER);
      // ignored while idle
      send_item(OP_SPARE, 8'hFF);
      send_item(OP_BYTE, 8'h3C);
      send_item(OP_TICK, 8'h00);
      // overflow
      send_item(OP_ARM, 8'hFF);
      send_item(OP_BYTE, RST_START_MARKER);
      send_item(OP_BYTE, RST_MAX_PAYLOAD + 8'd1);
      send_item(OP_BYTE, 8'hFF);
      // rearm mid-header, then zero length with a wrong end byte
      send_item(OP_ARM, 8'h00);
      send_item(OP_BYTE, RST_START_MARKER);
      send_item(OP_BYTE, RST_MAX_PAYLOAD);
      send_item(OP_ARM, 8'h00);
      send_item(OP_BYTE, RST_START_MARKER);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'hFF);
      settle();
      write_csr(REG_TIMEOUT_TICKS, 32'd0);
      send_item(OP_ARM, 8'h00);
      send_item(OP_TICK, 8'hFF);

      for (int p = 0; p < 8; p++) begin
         settle();
         idle_pct = 30;
         stall_pct <= 30;
         case (p)
            0: begin
               write_csr(REG_START_MARKER, 32'h00);
               write_csr(REG_END_MARKER, 32'hFF);
               write_csr(REG_MAX_PAYLOAD, 32'd0);
               write_csr(REG_TIMEOUT_TICKS, 32'd0);
            end
            1: begin
               write_csr(REG_START_MARKER, 32'hFF);
               write_csr(REG_END_MARKER, 32'h00);
               write_csr(REG_MAX_PAYLOAD, 32'd255);
               write_csr(REG_TIMEOUT_TICKS, 32'hFFFF);
            end
            default: begin
               write_csr(REG_START_MARKER, 32'($urandom_range(0, 255)));
               write_csr(REG_END_MARKER, 32'($urandom_range(0, 255)));
               write_csr(REG_MAX_PAYLOAD, 32'($urandom_range(0, 16)));
               write_csr(REG_TIMEOUT_TICKS, 32'($urandom_range(0, 4)));
            end
         endcase
         if (p == 2) begin
            hold_cycles <= 300;
            idle_pct = 0;
         end
         if (p == 3) begin
            idle_pct = 0;
            stall_pct <= 0;
         end
         target = sent + PhaseItems;
         while (sent < target) send_packet();
      end

      settle();
      if (sb.due_items.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d items still expected at end", $time, sb.due_items.size());
      end
      if (sb.errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
